/* design/lfhr_pkg.sv */
// ----------------------------------------------------------------------------
// lfhr_pkg
// Shared types, codes and decode functions for the link frame header receiver.
// ----------------------------------------------------------------------------
package lfhr_pkg;

  localparam int AddrWidth = 4;
  localparam int DataWidth = 32;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_FLAG    = 3'd1,
    PH_ADDR    = 3'd2,
    PH_CTRL    = 3'd3,
    PH_ENDFLAG = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SET   = 3'd0,
    KIND_UA    = 3'd1,
    KIND_DISC  = 3'd2,
    KIND_DATA  = 3'd3,
    KIND_REPLY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REPLY_NONE    = 3'd0,
    REPLY_READY0  = 3'd1,
    REPLY_READY1  = 3'd2,
    REPLY_REJECT0 = 3'd3,
    REPLY_REJECT1 = 3'd4
  } reply_t;

  typedef enum logic [1:0] {
    REG_FLAG    = 2'd0,
    REG_ADDRESS = 2'd1,
    REG_KIND    = 2'd2
  } reg_index_t;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [7:0] CtrlSet     = 8'h03;
  localparam logic [7:0] CtrlUa      = 8'h07;
  localparam logic [7:0] CtrlDisc    = 8'h0B;
  localparam logic [7:0] CtrlData0   = 8'h00;
  localparam logic [7:0] CtrlData1   = 8'h40;
  localparam logic [7:0] CtrlReady0  = 8'h05;
  localparam logic [7:0] CtrlReady1  = 8'h85;
  localparam logic [7:0] CtrlReject0 = 8'h01;
  localparam logic [7:0] CtrlReject1 = 8'h81;

  localparam logic [7:0] FlagReset    = 8'h7E;
  localparam logic [7:0] AddressReset = 8'h03;
  localparam logic [2:0] KindReset    = KIND_SET;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] address_byte;
    logic [2:0] expected_kind;
  } cfg_t;

  typedef struct packed {
    logic [2:0] frame_phase;
    logic [2:0] reply_code;
    logic [7:0] control_seen;
    logic       frame_done;
  } result_t;

  function automatic logic [2:0] reply_of(input logic [7:0] b);
    logic [2:0] code;
    case (b)
      CtrlReady0:  code = REPLY_READY0;
      CtrlReady1:  code = REPLY_READY1;
      CtrlReject0: code = REPLY_REJECT0;
      CtrlReject1: code = REPLY_REJECT1;
      default:     code = REPLY_NONE;
    endcase
    return code;
  endfunction

  function automatic logic control_ok(input logic [2:0] kind, input logic [7:0] b);
    logic ok;
    case (kind)
      KIND_SET:   ok = (b == CtrlSet);
      KIND_UA:    ok = (b == CtrlUa);
      KIND_DISC:  ok = (b == CtrlDisc);
      KIND_DATA:  ok = (b == CtrlData0) || (b == CtrlData1);
      KIND_REPLY: ok = (reply_of(b) != REPLY_NONE);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* design/lfhr_item_if.sv */
// ----------------------------------------------------------------------------
// lfhr_item_if
// Input channel: one received byte or a restart command per transfer.
// ----------------------------------------------------------------------------
interface lfhr_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

/* design/lfhr_result_if.sv */
// ----------------------------------------------------------------------------
// lfhr_result_if
// Output channel: receiver status after each input transfer.
// ----------------------------------------------------------------------------
interface lfhr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_phase;
  logic [2:0] reply_code;
  logic [7:0] control_seen;
  logic       frame_done;

  modport source (
    output valid, output frame_phase, output reply_code, output control_seen,
    output frame_done, input ready
  );
  modport sink (
    input valid, input frame_phase, input reply_code, input control_seen,
    input frame_done, output ready
  );
endinterface

/* design/lfhr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lfhr_cfg_regs
// APB register bank: flag byte, address byte and expected frame kind.
// ----------------------------------------------------------------------------
module lfhr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfhr_pkg::AddrWidth-1:0] paddr,
  input  logic [lfhr_pkg::DataWidth-1:0] pwdata,
  output logic [lfhr_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output lfhr_pkg::cfg_t                cfg
);
  import lfhr_pkg::*;

  logic [7:0] flag_byte;
  logic [7:0] address_byte;
  logic [2:0] expected_kind;
  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte     <= FlagReset;
      address_byte  <= AddressReset;
      expected_kind <= KindReset;
    end else if (wr_en) begin
      case (index)
        REG_FLAG:    flag_byte     <= pwdata[7:0];
        REG_ADDRESS: address_byte  <= pwdata[7:0];
        REG_KIND:    expected_kind <= pwdata[2:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_FLAG:    prdata = {{(DataWidth-8){1'b0}}, flag_byte};
      REG_ADDRESS: prdata = {{(DataWidth-8){1'b0}}, address_byte};
      REG_KIND:    prdata = {{(DataWidth-3){1'b0}}, expected_kind};
      default:     prdata = '0;
    endcase
  end

  assign cfg.flag_byte     = flag_byte;
  assign cfg.address_byte  = address_byte;
  assign cfg.expected_kind = expected_kind;
endmodule

/* design/lfhr_core.sv */
// ----------------------------------------------------------------------------
// lfhr_core
// Frame phase tracker: phase, last control byte and reply code, updated
// once per advancing item.
// ----------------------------------------------------------------------------
module lfhr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             operation,
  input  logic [7:0]       rx_byte,
  input  lfhr_pkg::cfg_t   cfg,
  output lfhr_pkg::result_t result
);
  import lfhr_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] control_reg;
  logic [7:0] control_reg_next;
  logic [2:0] reply_reg;
  logic [2:0] reply_reg_next;
  logic       is_flag;

  assign is_flag = (rx_byte == cfg.flag_byte);

  always_comb begin
    phase_next       = phase;
    control_reg_next = control_reg;
    reply_reg_next   = reply_reg;
    if (operation == OP_RESTART) begin
      phase_next     = PH_START;
      reply_reg_next = REPLY_NONE;
    end else begin
      case (phase)
        PH_START: begin
          if (is_flag) phase_next = PH_FLAG;
        end
        PH_FLAG: begin
          if (!is_flag) begin
            phase_next = (rx_byte == cfg.address_byte) ? PH_ADDR : PH_START;
          end
        end
        PH_ADDR: begin
          if (is_flag) begin
            phase_next = PH_FLAG;
          end else if (control_ok(cfg.expected_kind, rx_byte)) begin
            control_reg_next = rx_byte;
            phase_next       = PH_CTRL;
            if (cfg.expected_kind == KIND_REPLY) reply_reg_next = reply_of(rx_byte);
          end else begin
            phase_next = PH_START;
          end
        end
        PH_CTRL: begin
          if (rx_byte == (cfg.address_byte ^ control_reg)) begin
            phase_next = (cfg.expected_kind == KIND_DATA) ? PH_PAYLOAD : PH_ENDFLAG;
          end else if (is_flag) begin
            phase_next = PH_FLAG;
          end else begin
            phase_next = PH_START;
          end
        end
        PH_ENDFLAG: phase_next = is_flag ? PH_DONE : PH_START;
        PH_PAYLOAD: begin
          if (is_flag) phase_next = PH_DONE;
        end
        PH_DONE:    phase_next = PH_DONE;
        default:    phase_next = PH_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      control_reg <= 8'h00;
      reply_reg   <= REPLY_NONE;
    end else if (advance) begin
      phase       <= phase_next;
      control_reg <= control_reg_next;
      reply_reg   <= reply_reg_next;
    end
  end

  assign result.frame_phase  = phase_next;
  assign result.reply_code   = reply_reg_next;
  assign result.control_seen = control_reg_next;
  assign result.frame_done   = (phase_next == PH_DONE);
endmodule

/* design/link_frame_header_receiver_unit.sv */
// ----------------------------------------------------------------------------
// link_frame_header_receiver_unit
// Byte-wise receiver for flag/address/control/BCC/flag frame headers.
// ----------------------------------------------------------------------------
// Each input transfer carries one received byte or a restart command and
// produces exactly one status result. The block takes one item per clock
// cycle when the output is not stalled; each item passes the input register
// and then the result register. The rate is set by the update of the phase,
// control and reply registers, which close on themselves each item. Both
// stages hold under output backpressure; while a finished result waits to be
// taken, the input register takes one more item and then holds it. Configure
// through the APB port only while no item is in flight.
module link_frame_header_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  lfhr_item_if.sink                     item,
  lfhr_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfhr_pkg::AddrWidth-1:0] paddr,
  input  logic [lfhr_pkg::DataWidth-1:0] pwdata,
  output logic [lfhr_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import lfhr_pkg::*;

  cfg_t       cfg;
  result_t    core_result;
  result_t    out_data;
  logic       hold_valid;
  logic       hold_operation;
  logic [7:0] hold_byte;
  logic       out_valid;
  logic       advance;

  lfhr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance    = hold_valid && (!out_valid || result.ready);
  assign item.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_operation <= item.operation;
      hold_byte      <= item.rx_byte;
    end
  end

  lfhr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .operation (hold_operation),
    .rx_byte   (hold_byte),
    .cfg       (cfg),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= core_result;
  end

  assign result.valid        = out_valid;
  assign result.frame_phase  = out_data.frame_phase;
  assign result.reply_code   = out_data.reply_code;
  assign result.control_seen = out_data.control_seen;
  assign result.frame_done   = out_data.frame_done;
endmodule

/* design/lfhr_checker.sv */
// ----------------------------------------------------------------------------
// lfhr_checker
// Port-level checks for the link frame header receiver, bound to the top.
// ----------------------------------------------------------------------------
module lfhr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] frame_phase,
  input logic [2:0] reply_code,
  input logic [7:0] control_seen,
  input logic       frame_done
);
  import lfhr_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_done == (frame_phase == PH_DONE)))
    else $error("frame_done disagrees with frame_phase");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      ($stable(frame_phase) && $stable(reply_code) && $stable(control_seen)))
    else $error("stalled result changed");
endmodule

bind link_frame_header_receiver_unit lfhr_checker u_lfhr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .frame_phase  (result.frame_phase),
  .reply_code   (result.reply_code),
  .control_seen (result.control_seen),
  .frame_done   (result.frame_done)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the link frame header receiver unit.
// ----------------------------------------------------------------------------
// A directed table runs first: reset status, the field extremes, restart, the
// done hold, repeated flags, a flag in place of the control byte, reply codes,
// payload skipping, a BCC that equals the flag, and an unused frame kind.
// Random phases follow, each with its own register setting and one of four
// idle patterns, sending mostly well-formed frames with random content mixed
// with broken frames, noise bytes and restarts. Every result is checked field
// by field: table rows against the table, others against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
  import lfhr_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems    = 100;

  typedef struct {
    bit         is_cfg;
    reg_index_t idx;
    logic [7:0] val;
    logic       op;
    logic [7:0] data;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrWidth-1:0] paddr   = '0;
  logic [DataWidth-1:0] pwdata  = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  lfhr_item_if   item_ch ();
  lfhr_result_if result_ch ();

  link_frame_header_receiver_unit uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // receiver model state and settings
  logic [7:0] flag_cfg = FlagReset;
  logic [7:0] addr_cfg = AddressReset;
  logic [2:0] kind_cfg = KindReset;
  phase_t     rx_phase = PH_START;
  logic [7:0] rx_ctrl  = 8'h00;
  logic [2:0] rx_reply = REPLY_NONE;

  result_t   status_due[$];
  stim_row_t header_table[$];
  int        err_count  = 0;
  int        items_sent = 0;
  int        send_idle  = 0;
  int        recv_stall = 0;
  int        quiet_cycles = 0;

  always #4 clk = ~clk;

  function automatic logic [2:0] reply_for(input logic [7:0] b);
    if (b == CtrlReady0) return REPLY_READY0;
    if (b == CtrlReady1) return REPLY_READY1;
    if (b == CtrlReject0) return REPLY_REJECT0;
    if (b == CtrlReject1) return REPLY_REJECT1;
    return REPLY_NONE;
  endfunction

  function automatic bit ctrl_accepted(input logic [7:0] b);
    case (kind_cfg)
      KIND_SET:   return b == CtrlSet;
      KIND_UA:    return b == CtrlUa;
      KIND_DISC:  return b == CtrlDisc;
      KIND_DATA:  return (b == CtrlData0) || (b == CtrlData1);
      KIND_REPLY: return reply_for(b) != REPLY_NONE;
      default:    return 1'b0;
    endcase
  endfunction

  // advance the receiver model by one item and return the status it shows
  function automatic result_t next_frame_status(input logic op, input logic [7:0] b);
    result_t r;
    if (op == OP_RESTART) begin
      rx_phase = PH_START;
      rx_reply = REPLY_NONE;
    end else begin
      case (rx_phase)
        PH_START: begin
          if (b == flag_cfg) rx_phase = PH_FLAG;
        end
        PH_FLAG: begin
          if (b != flag_cfg) rx_phase = (b == addr_cfg) ? PH_ADDR : PH_START;
        end
        PH_ADDR: begin
          if (b == flag_cfg) begin
            rx_phase = PH_FLAG;
          end else if (ctrl_accepted(b)) begin
            rx_ctrl  = b;
            rx_phase = PH_CTRL;
            if (kind_cfg == KIND_REPLY) rx_reply = reply_for(b);
          end else begin
            rx_phase = PH_START;
          end
        end
        PH_CTRL: begin
          if (b == (addr_cfg ^ rx_ctrl)) begin
            rx_phase = (kind_cfg == KIND_DATA) ? PH_PAYLOAD : PH_ENDFLAG;
          end else if (b == flag_cfg) begin
            rx_phase = PH_FLAG;
          end else begin
            rx_phase = PH_START;
          end
        end
        PH_ENDFLAG: rx_phase = (b == flag_cfg) ? PH_DONE : PH_START;
        PH_PAYLOAD: begin
          if (b == flag_cfg) rx_phase = PH_DONE;
        end
        PH_DONE: ;
        default: rx_phase = PH_START;
      endcase
    end
    r.frame_phase  = rx_phase;
    r.reply_code   = rx_reply;
    r.control_seen = rx_ctrl;
    r.frame_done   = (rx_phase == PH_DONE);
    return r;
  endfunction

  function automatic void tab_cfg(input reg_index_t idx, input logic [7:0] val);
    stim_row_t row;
    row        = '{idx: REG_FLAG, default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    header_table.push_back(row);
  endfunction

  function automatic void tab_want(input logic op, input logic [7:0] b, input phase_t ph,
                                   input logic [2:0] rp, input logic [7:0] ct);
    stim_row_t row;
    row       = '{idx: REG_FLAG, default: '0};
    row.op    = op;
    row.data  = b;
    row.typed = 1'b1;
    row.want  = '{ph, rp, ct, ph == PH_DONE};
    header_table.push_back(row);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input bit typed,
                           input result_t want);
    result_t got;
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.rx_byte   <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    got = next_frame_status(op, b);
    status_due.push_back(typed ? want : got);
    items_sent++;
  endtask

  // drain, let the pipeline settle, then write one register
  task automatic reg_write(input reg_index_t idx, input logic [7:0] val);
    item_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataWidth'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FLAG:    flag_cfg = val;
      REG_ADDRESS: addr_cfg = val;
      default:     kind_cfg = val[2:0];
    endcase
  endtask

  // one frame, broken frame, noise burst or restart
  task automatic send_frame();
    logic [7:0] seq[$];
    logic [7:0] ctl;
    logic [7:0] pay;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_item(OP_RESTART, 8'($urandom), 1'b0, '0);
      return;
    end
    if (pick < 16) begin
      repeat ($urandom_range(1, 4)) send_item(OP_BYTE, 8'($urandom), 1'b0, '0);
      return;
    end
    case (kind_cfg)
      KIND_SET:  ctl = CtrlSet;
      KIND_UA:   ctl = CtrlUa;
      KIND_DISC: ctl = CtrlDisc;
      KIND_DATA: ctl = $urandom_range(1) ? CtrlData1 : CtrlData0;
      KIND_REPLY: begin
        case ($urandom_range(3))
          0: ctl = CtrlReady0;
          1: ctl = CtrlReady1;
          2: ctl = CtrlReject0;
          default: ctl = CtrlReject1;
        endcase
      end
      default: ctl = 8'($urandom);
    endcase
    if ($urandom_range(99) < 12) ctl = 8'($urandom);
    repeat ($urandom_range(1, 2)) seq.push_back(flag_cfg);
    seq.push_back(addr_cfg);
    seq.push_back(ctl);
    seq.push_back(addr_cfg ^ ctl);
    if (kind_cfg == KIND_DATA) begin
      repeat ($urandom_range(0, 4)) begin
        pay = 8'($urandom);
        if (pay == flag_cfg) pay = pay ^ 8'h01;
        seq.push_back(pay);
      end
    end
    seq.push_back(flag_cfg);
    if (pick >= 82) seq[$urandom_range(0, seq.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    foreach (seq[i]) send_item(OP_BYTE, seq[i], 1'b0, '0);
    if ($urandom_range(3) != 0) send_item(OP_RESTART, 8'($urandom), 1'b0, '0);
  endtask

  // result checking and receiver backpressure
  always @(posedge clk) begin
    result_t due;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("result transfer with no expectation pending");
        err_count++;
      end else begin
        due = status_due.pop_front();
        if (result_ch.frame_phase !== due.frame_phase) begin
          $error("frame_phase expected %0d got %0d", due.frame_phase, result_ch.frame_phase);
          err_count++;
        end
        if (result_ch.reply_code !== due.reply_code) begin
          $error("reply_code expected %0d got %0d", due.reply_code, result_ch.reply_code);
          err_count++;
        end
        if (result_ch.control_seen !== due.control_seen) begin
          $error("control_seen expected %02h got %02h", due.control_seen,
                 result_ch.control_seen);
          err_count++;
        end
        if (result_ch.frame_done !== due.frame_done) begin
          $error("frame_done expected %0d got %0d", due.frame_done, result_ch.frame_done);
          err_count++;
        end
      end
    end
    result_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    int target;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_BYTE;
    item_ch.rx_byte   = 8'h00;
    result_ch.ready   = 1'b0;

    tab_want(OP_BYTE,    8'h00, PH_START,   REPLY_NONE,    8'h00);
    tab_want(OP_BYTE,    8'h7E, PH_FLAG,    REPLY_NONE,    8'h00);
    tab_want(OP_BYTE,    8'h7E, PH_FLAG,    REPLY_NONE,    8'h00);
    tab_want(OP_BYTE,    8'h03, PH_ADDR,    REPLY_NONE,    8'h00);
    tab_want(OP_BYTE,    8'h7E, PH_FLAG,    REPLY_NONE,    8'h00);
    tab_want(OP_BYTE,    8'h03, PH_ADDR,    REPLY_NONE,    8'h00);
    tab_want(OP_BYTE,    8'h03, PH_CTRL,    REPLY_NONE,    8'h03);
    tab_want(OP_BYTE,    8'h00, PH_ENDFLAG, REPLY_NONE,    8'h03);
    tab_want(OP_BYTE,    8'h7E, PH_DONE,    REPLY_NONE,    8'h03);
    tab_want(OP_BYTE,    8'hFF, PH_DONE,    REPLY_NONE,    8'h03);
    tab_want(OP_RESTART, 8'h00, PH_START,   REPLY_NONE,    8'h03);
    tab_cfg(REG_KIND, 8'(KIND_REPLY));
    tab_want(OP_BYTE,    8'h7E, PH_FLAG,    REPLY_NONE,    8'h03);
    tab_want(OP_BYTE,    8'h03, PH_ADDR,    REPLY_NONE,    8'h03);
    tab_want(OP_BYTE,    8'h81, PH_CTRL,    REPLY_REJECT1, 8'h81);
    tab_want(OP_BYTE,    8'h82, PH_ENDFLAG, REPLY_REJECT1, 8'h81);
    tab_want(OP_BYTE,    8'h00, PH_START,   REPLY_REJECT1, 8'h81);
    tab_want(OP_RESTART, 8'hFF, PH_START,   REPLY_NONE,    8'h81);
    tab_cfg(REG_FLAG, 8'h00);
    tab_cfg(REG_ADDRESS, 8'h40);
    tab_cfg(REG_KIND, 8'(KIND_DATA));
    tab_want(OP_BYTE,    8'h00, PH_FLAG,    REPLY_NONE,    8'h81);
    tab_want(OP_BYTE,    8'h40, PH_ADDR,    REPLY_NONE,    8'h81);
    tab_want(OP_BYTE,    8'h40, PH_CTRL,    REPLY_NONE,    8'h40);
    tab_want(OP_BYTE,    8'h00, PH_PAYLOAD, REPLY_NONE,    8'h40);
    tab_want(OP_BYTE,    8'h55, PH_PAYLOAD, REPLY_NONE,    8'h40);
    tab_want(OP_BYTE,    8'h00, PH_DONE,    REPLY_NONE,    8'h40);
    tab_cfg(REG_KIND, 8'd7);
    tab_cfg(REG_FLAG, 8'hFF);
    tab_cfg(REG_ADDRESS, 8'h00);
    tab_want(OP_RESTART, 8'h00, PH_START,   REPLY_NONE,    8'h40);
    tab_want(OP_BYTE,    8'hFF, PH_FLAG,    REPLY_NONE,    8'h40);
    tab_want(OP_BYTE,    8'h00, PH_ADDR,    REPLY_NONE,    8'h40);
    tab_want(OP_BYTE,    8'h03, PH_START,   REPLY_NONE,    8'h40);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (header_table[i]) begin
      if (header_table[i].is_cfg) begin
        reg_write(header_table[i].idx, header_table[i].val);
      end else begin
        send_item(header_table[i].op, header_table[i].data, header_table[i].typed,
                  header_table[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          reg_write(REG_FLAG, FlagReset);
          reg_write(REG_ADDRESS, AddressReset);
          reg_write(REG_KIND, 8'(KIND_SET));
        end
        1: begin
          reg_write(REG_FLAG, 8'h00);
          reg_write(REG_ADDRESS, 8'hFF);
          reg_write(REG_KIND, 8'(KIND_REPLY));
        end
        2: begin
          reg_write(REG_FLAG, 8'hFF);
          reg_write(REG_ADDRESS, 8'h00);
          reg_write(REG_KIND, 8'(KIND_DATA));
        end
        default: begin
          reg_write(REG_FLAG, 8'($urandom));
          reg_write(REG_ADDRESS, 8'($urandom));
          case (p)
            3: reg_write(REG_KIND, 8'(KIND_UA));
            4: reg_write(REG_KIND, 8'(KIND_DISC));
            5: reg_write(REG_KIND, 8'(KIND_REPLY));
            6: reg_write(REG_KIND, 8'(KIND_DATA));
            default: reg_write(REG_KIND, 8'($urandom_range(5, 7)));
          endcase
        end
      endcase
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) send_frame();
    end

    item_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
